[rtl/core/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on clk_i, quiet while rst_ni is low
`define HLFX_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// expression that must never be true on a clock edge
`define HLFX_ASSERT_NEVER(label, expr, msg) \
  `HLFX_ASSERT(label, !(expr), msg)

`endif

[rtl/core/hlfx_pkg.sv]
package hlfx_pkg;

  // commands
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_DATA  = 2'd1;
  localparam logic [1:0] CMD_FETCH = 2'd2;

  // reported status
  localparam logic [1:0] STATUS_PARSING = 2'd0;
  localparam logic [1:0] STATUS_READY   = 2'd1;
  localparam logic [1:0] STATUS_ERROR   = 2'd2;

  // parser phases
  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_LEN    = 3'd1;
  localparam logic [2:0] PH_BODY   = 3'd2;
  localparam logic [2:0] PH_READY  = 3'd3;
  localparam logic [2:0] PH_ERROR  = 3'd4;

  // source of a fetched name character
  localparam logic [1:0] SEL_NONE  = 2'd0;
  localparam logic [1:0] SEL_FIRST = 2'd1;
  localparam logic [1:0] SEL_SPACE = 2'd2;
  localparam logic [1:0] SEL_LAST  = 2'd3;

  // record layout
  localparam logic [2:0] HDR_DIGITS       = 3'd6;
  localparam logic [2:0] LEN_DIGITS       = 3'd2;
  localparam logic [2:0] NUM_FIELDS       = 3'd5;
  localparam logic [2:0] FIELD_LAST_NAME  = 3'd3;
  localparam logic [2:0] FIELD_FIRST_NAME = 3'd4;

  localparam logic [7:0]  SPACE_CHAR   = 8'h20;
  localparam logic [10:0] CAP_RESET    = 11'd512;
  localparam int unsigned PTR_W        = 9;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] name_byte;
    logic       name_valid;
    logic       name_last;
  } out_item_t;

  // per-item result leaving the parser
  typedef struct packed {
    logic [1:0] status;
    logic       name_valid;
    logic       name_last;
    logic [1:0] name_sel;
  } step_res_t;

  // name store write strobes
  typedef struct packed {
    logic       we_first;
    logic       we_last;
    logic [7:0] data;
  } store_wr_t;

  // ascii hex digit decode: {ok, value}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c inside {[8'h61:8'h66]}) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c inside {[8'h41:8'h46]}) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

[rtl/core/hlfx_name_mem.sv]
module hlfx_name_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/hlfx_parser.sv]
module hlfx_parser #(
  parameter int unsigned MAX_RECORD  = 400,
  parameter int unsigned FIELD_STORE = 256,
  parameter int unsigned AW          = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  hlfx_pkg::in_item_t  item_i,
  input  logic [10:0]         capacity_i,
  output hlfx_pkg::step_res_t step_o,
  output hlfx_pkg::store_wr_t wr_o,
  output logic [AW-1:0]       waddr_o,
  output logic [AW-1:0]       raddr_first_o,
  output logic [AW-1:0]       raddr_last_o
);

  localparam int unsigned RW  = $clog2(MAX_RECORD);
  localparam int unsigned SW  = ((RW > 8) ? RW : 8) + 1;
  localparam int unsigned LIM = MAX_RECORD - 6;

  logic [2:0]          phase_q, phase_d;
  logic [23:0]         acc_q, acc_d;
  logic [2:0]          digit_q, digit_d;
  logic [RW-1:0]       size_q, size_d;
  logic [RW-1:0]       offset_q, offset_d;
  logic [2:0]          field_q, field_d;
  logic [7:0]          remain_q, remain_d;
  logic [7:0]          last_len_q, last_len_d;
  logic [7:0]          first_len_q, first_len_d;
  logic [7:0]          last_eff_q, last_eff_d;
  logic [7:0]          first_eff_q, first_eff_d;
  logic                last_zero_q, last_zero_d;
  logic                first_zero_q, first_zero_d;
  logic [hlfx_pkg::PTR_W-1:0] fetch_q, fetch_d;

  logic [4:0]                 hex;
  logic [23:0]                acc_new;
  logic [2:0]                 digit_new;
  logic [7:0]                 fsz;
  logic                       do_finish;
  logic [2:0]                 field_inc;
  logic [10:0]                name_need;
  logic [hlfx_pkg::PTR_W-1:0] total;
  logic [hlfx_pkg::PTR_W-1:0] last_idx;
  logic [7:0]                 wr_idx;

  assign hex       = hlfx_pkg::hex_decode(item_i.data_byte);
  assign acc_new   = {acc_q[19:0], hex[3:0]};
  assign digit_new = digit_q + 3'd1;
  assign fsz       = acc_new[7:0];
  assign wr_idx    = (field_q == hlfx_pkg::FIELD_LAST_NAME) ? (last_len_q - remain_q)
                                                            : (first_len_q - remain_q);
  assign total     = hlfx_pkg::PTR_W'(first_eff_q) + hlfx_pkg::PTR_W'(last_eff_q)
                     + hlfx_pkg::PTR_W'(1);
  assign last_idx  = fetch_q - hlfx_pkg::PTR_W'(first_eff_q) - hlfx_pkg::PTR_W'(1);

  // fetch read addresses, both stores looked up every item
  assign raddr_first_o = fetch_q[AW-1:0];
  assign raddr_last_o  = last_idx[AW-1:0];
  assign waddr_o       = wr_idx[AW-1:0];

  // next state for one accepted item
  always_comb begin
    phase_d      = phase_q;
    acc_d        = acc_q;
    digit_d      = digit_q;
    size_d       = size_q;
    offset_d     = offset_q;
    field_d      = field_q;
    remain_d     = remain_q;
    last_len_d   = last_len_q;
    first_len_d  = first_len_q;
    last_eff_d   = last_eff_q;
    first_eff_d  = first_eff_q;
    last_zero_d  = last_zero_q;
    first_zero_d = first_zero_q;
    fetch_d      = fetch_q;
    do_finish    = 1'b0;
    field_inc    = field_q + 3'd1;
    name_need    = 11'd0;
    wr_o         = '0;
    wr_o.data    = item_i.data_byte;
    step_o       = '0;
    step_o.name_sel = hlfx_pkg::SEL_NONE;

    if (accept_i) begin
      case (item_i.cmd)
        hlfx_pkg::CMD_START: begin
          phase_d      = hlfx_pkg::PH_HEADER;
          acc_d        = '0;
          digit_d      = '0;
          size_d       = '0;
          offset_d     = '0;
          field_d      = '0;
          remain_d     = '0;
          last_len_d   = '0;
          first_len_d  = '0;
          last_eff_d   = '0;
          first_eff_d  = '0;
          last_zero_d  = 1'b0;
          first_zero_d = 1'b0;
          fetch_d      = '0;
        end
        hlfx_pkg::CMD_DATA: begin
          case (phase_q)
            hlfx_pkg::PH_HEADER, hlfx_pkg::PH_LEN: begin
              if (!hex[4]) begin
                phase_d = hlfx_pkg::PH_ERROR;
              end else begin
                acc_d   = acc_new;
                digit_d = digit_new;
                if (phase_q == hlfx_pkg::PH_HEADER) begin
                  // six size digits, clamped
                  if (digit_new >= hlfx_pkg::HDR_DIGITS) begin
                    size_d   = (acc_new > 24'(LIM)) ? RW'(LIM) : acc_new[RW-1:0];
                    offset_d = '0;
                    field_d  = '0;
                    phase_d  = hlfx_pkg::PH_LEN;
                    acc_d    = '0;
                    digit_d  = '0;
                  end
                end else if (digit_new >= hlfx_pkg::LEN_DIGITS) begin
                  // field length against record size and store depth
                  if ((SW'(fsz) + SW'(offset_q)) > SW'(size_q)) begin
                    phase_d = hlfx_pkg::PH_ERROR;
                  end else begin
                    offset_d = offset_q + RW'(2);
                    if ({1'b0, fsz} >= 9'(FIELD_STORE)) begin
                      phase_d = hlfx_pkg::PH_ERROR;
                    end else begin
                      remain_d = fsz;
                      if (field_q == hlfx_pkg::FIELD_LAST_NAME) begin
                        last_len_d = fsz;
                      end
                      if (field_q == hlfx_pkg::FIELD_FIRST_NAME) begin
                        first_len_d = fsz;
                      end
                      if (fsz == 8'd0) begin
                        do_finish = 1'b1;
                      end else begin
                        phase_d = hlfx_pkg::PH_BODY;
                      end
                    end
                  end
                end
              end
            end
            hlfx_pkg::PH_BODY: begin
              // buffer name bytes, track length up to first zero
              if (field_q == hlfx_pkg::FIELD_LAST_NAME) begin
                wr_o.we_last = 1'b1;
                if (item_i.data_byte == 8'd0) begin
                  last_zero_d = 1'b1;
                end else if (!last_zero_q) begin
                  last_eff_d = last_eff_q + 8'd1;
                end
              end else if (field_q == hlfx_pkg::FIELD_FIRST_NAME) begin
                wr_o.we_first = 1'b1;
                if (item_i.data_byte == 8'd0) begin
                  first_zero_d = 1'b1;
                end else if (!first_zero_q) begin
                  first_eff_d = first_eff_q + 8'd1;
                end
              end
              offset_d = offset_q + RW'(1);
              remain_d = remain_q - 8'd1;
              if (remain_q == 8'd1) begin
                do_finish = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
        hlfx_pkg::CMD_FETCH: begin
          if (phase_q == hlfx_pkg::PH_READY && fetch_q < total) begin
            step_o.name_valid = 1'b1;
            step_o.name_last  = ((fetch_q + hlfx_pkg::PTR_W'(1)) == total);
            if (fetch_q < hlfx_pkg::PTR_W'(first_eff_q)) begin
              step_o.name_sel = hlfx_pkg::SEL_FIRST;
            end else if (fetch_q == hlfx_pkg::PTR_W'(first_eff_q)) begin
              step_o.name_sel = hlfx_pkg::SEL_SPACE;
            end else begin
              step_o.name_sel = hlfx_pkg::SEL_LAST;
            end
            fetch_d = fetch_q + hlfx_pkg::PTR_W'(1);
          end
        end
        default: begin
        end
      endcase

      // end of a field: next length, capacity check or offset check
      if (do_finish) begin
        field_d   = field_inc;
        name_need = 11'(first_len_d) + 11'(last_len_d) + 11'd1;
        if (field_inc >= hlfx_pkg::NUM_FIELDS) begin
          phase_d = (name_need >= capacity_i) ? hlfx_pkg::PH_ERROR : hlfx_pkg::PH_READY;
        end else if (offset_d > size_q) begin
          phase_d = hlfx_pkg::PH_ERROR;
        end else begin
          phase_d = hlfx_pkg::PH_LEN;
          acc_d   = '0;
          digit_d = '0;
        end
      end
    end

    case (phase_d)
      hlfx_pkg::PH_READY: step_o.status = hlfx_pkg::STATUS_READY;
      hlfx_pkg::PH_ERROR: step_o.status = hlfx_pkg::STATUS_ERROR;
      default:            step_o.status = hlfx_pkg::STATUS_PARSING;
    endcase
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= hlfx_pkg::PH_HEADER;
      acc_q        <= '0;
      digit_q      <= '0;
      size_q       <= '0;
      offset_q     <= '0;
      field_q      <= '0;
      remain_q     <= '0;
      last_len_q   <= '0;
      first_len_q  <= '0;
      last_eff_q   <= '0;
      first_eff_q  <= '0;
      last_zero_q  <= 1'b0;
      first_zero_q <= 1'b0;
      fetch_q      <= '0;
    end else begin
      phase_q      <= phase_d;
      acc_q        <= acc_d;
      digit_q      <= digit_d;
      size_q       <= size_d;
      offset_q     <= offset_d;
      field_q      <= field_d;
      remain_q     <= remain_d;
      last_len_q   <= last_len_d;
      first_len_q  <= first_len_d;
      last_eff_q   <= last_eff_d;
      first_eff_q  <= first_eff_d;
      last_zero_q  <= last_zero_d;
      first_zero_q <= first_zero_d;
      fetch_q      <= fetch_d;
    end
  end

endmodule

[rtl/core/hex_length_field_name_extractor.sv]
// Record name extractor: takes one command per cycle (start, record byte or fetch) and
// returns exactly one result per command via the input stage and output registers. A
// record is a six-digit ASCII-hex size, clamped to MAX_RECORD - 6, followed by five
// fields of two hex length digits and their bytes; fields four and five (last and first
// name) go into two FIELD_STORE-byte name stores. Status reads 0 while parsing, 1 once
// the name is ready and 2 on a bad hex digit, a field running past the record size, a
// field of FIELD_STORE bytes or more or a name that does not fit name_capacity. Fetches
// then return the name as "first last", one byte each, with name_last on the final
// character. The parser state and the name store write/read address settle at the input
// transfer, the store read data is registered there, and the output register holds the
// result, so a new command is taken every cycle while the output side keeps up. The name
// stores are not cleared after reset; only written entries ever reach the output.
`include "assert_macros.svh"

module hex_length_field_name_extractor #(
  parameter int unsigned MAX_RECORD  = 400,
  parameter int unsigned FIELD_STORE = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  hlfx_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output hlfx_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [10:0]         cfg_data_i
);

  localparam int unsigned AW = $clog2(FIELD_STORE);

  logic                in_accept;
  logic                s1_advance;
  logic                s1_valid_q;
  hlfx_pkg::step_res_t s1_res_q;
  hlfx_pkg::step_res_t step_res;
  hlfx_pkg::store_wr_t store_wr;
  logic [AW-1:0]       waddr;
  logic [AW-1:0]       raddr_first;
  logic [AW-1:0]       raddr_last;
  logic [7:0]          rdata_first;
  logic [7:0]          rdata_last;
  logic [10:0]         capacity_q;
  logic                out_valid_q;
  hlfx_pkg::out_item_t out_q, out_d;

  // pipeline flow control
  assign s1_advance = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_advance;
  assign in_accept  = in_valid_i && in_ready_o;

  // name capacity register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= hlfx_pkg::CAP_RESET;
    end else if (cfg_valid_i) begin
      capacity_q <= cfg_data_i;
    end
  end

  hlfx_parser #(
    .MAX_RECORD  (MAX_RECORD),
    .FIELD_STORE (FIELD_STORE),
    .AW          (AW)
  ) u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (in_accept),
    .item_i        (in_data_i),
    .capacity_i    (capacity_q),
    .step_o        (step_res),
    .wr_o          (store_wr),
    .waddr_o       (waddr),
    .raddr_first_o (raddr_first),
    .raddr_last_o  (raddr_last)
  );

  hlfx_name_mem #(
    .DEPTH (FIELD_STORE),
    .AW    (AW)
  ) u_first_mem (
    .clk_i   (clk_i),
    .we_i    (store_wr.we_first),
    .waddr_i (waddr),
    .wdata_i (store_wr.data),
    .re_i    (in_accept),
    .raddr_i (raddr_first),
    .rdata_o (rdata_first)
  );

  hlfx_name_mem #(
    .DEPTH (FIELD_STORE),
    .AW    (AW)
  ) u_last_mem (
    .clk_i   (clk_i),
    .we_i    (store_wr.we_last),
    .waddr_i (waddr),
    .wdata_i (store_wr.data),
    .re_i    (in_accept),
    .raddr_i (raddr_last),
    .rdata_o (rdata_last)
  );

  // input stage, alongside the store read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_res_q <= step_res;
    end
  end

  // pick the name character
  always_comb begin
    out_d            = '0;
    out_d.status     = s1_res_q.status;
    out_d.name_valid = s1_res_q.name_valid;
    out_d.name_last  = s1_res_q.name_last;
    case (s1_res_q.name_sel)
      hlfx_pkg::SEL_FIRST: out_d.name_byte = rdata_first;
      hlfx_pkg::SEL_SPACE: out_d.name_byte = hlfx_pkg::SPACE_CHAR;
      hlfx_pkg::SEL_LAST:  out_d.name_byte = rdata_last;
      default:             out_d.name_byte = 8'd0;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  `HLFX_ASSERT(a_char_only_when_ready, out_valid_o && out_data_o.name_valid |-> out_data_o.status == hlfx_pkg::STATUS_READY, "name character without ready status")
  `HLFX_ASSERT_NEVER(a_last_needs_char, out_valid_o && out_data_o.name_last && !out_data_o.name_valid, "name_last without a name character")
  `HLFX_ASSERT(a_stall_only_when_full, !in_ready_o |-> s1_valid_q && out_valid_q, "input stalled with a free stage")
  `HLFX_ASSERT(a_char_has_source, s1_valid_q && s1_res_q.name_valid |-> s1_res_q.name_sel != hlfx_pkg::SEL_NONE, "fetched character without a source")

endmodule

[tb/sv/hex_length_field_name_extractor_tb.sv]
module hex_length_field_name_extractor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // no-op command code, not named in the package
  localparam logic [1:0] CMD_NOP = 2'd3;
  localparam int RECORD_LIMIT = 400;
  localparam int SIZE_CLAMP = RECORD_LIMIT - hlfx_pkg::HDR_DIGITS;
  localparam int PHASE_ITEMS = 95;
  localparam int NUM_PHASES = 7;
  localparam int SETTLE_CYCLES = 4;
  localparam int CYCLE_LIMIT = 400000;
  localparam int REPORT_LIMIT = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  hlfx_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  hlfx_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [10:0] cfg_data = '0;

  // stimulus and scoreboard storage
  hlfx_pkg::in_item_t cmd_backlog [$];
  hlfx_pkg::in_item_t record_buf [$];
  hlfx_pkg::out_item_t predicted_outputs [$];
  hlfx_pkg::out_item_t popped_result;
  int staged_count;
  int gap_pct = 29;
  int mismatch_count = 0;
  int cycle_count = 0;
  logic [10:0] phase_caps [NUM_PHASES];

  // shadow copy of the parser state
  logic [10:0] name_cap;
  logic [2:0] ph;
  logic [23:0] hex_acc;
  logic [2:0] dig_cnt;
  logic [8:0] rec_size;
  logic [8:0] rec_off;
  logic [2:0] fld_idx;
  logic [7:0] fld_rem;
  logic [7:0] lname_len;
  logic [7:0] fname_len;
  logic [7:0] lname_mem [256];
  logic [7:0] fname_mem [256];
  int unsigned fetch_ptr;
  int unsigned lname_eff;
  int unsigned fname_eff;
  logic lname_zero;
  logic fname_zero;

  hex_length_field_name_extractor uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ascii hex digit: {ok, value}
  function automatic logic [4:0] digit_value(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b1, c[3:0]};
    if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      return {1'b1, 4'(c[3:0] + 4'd9)};
    end
    return 5'd0;
  endfunction

  function automatic void restart_parse();
    ph = hlfx_pkg::PH_HEADER;
    hex_acc = '0;
    dig_cnt = '0;
    rec_size = '0;
    rec_off = '0;
    fld_idx = '0;
    fld_rem = '0;
    lname_len = '0;
    fname_len = '0;
    fetch_ptr = 0;
    lname_eff = 0;
    fname_eff = 0;
    lname_zero = 1'b0;
    fname_zero = 1'b0;
  endfunction

  // end of a field: next length, name check or error
  function automatic void close_field();
    fld_idx = fld_idx + 3'd1;
    if (fld_idx >= hlfx_pkg::NUM_FIELDS) begin
      if (int'(fname_len) + int'(lname_len) + 1 >= int'(name_cap)) ph = hlfx_pkg::PH_ERROR;
      else ph = hlfx_pkg::PH_READY;
    end else if (rec_off > rec_size) begin
      ph = hlfx_pkg::PH_ERROR;
    end else begin
      ph = hlfx_pkg::PH_LEN;
      hex_acc = '0;
      dig_cnt = '0;
    end
  endfunction

  function automatic void take_record_byte(logic [7:0] b);
    logic [4:0] dv;
    logic [7:0] fsz;
    logic [7:0] k;
    if (ph == hlfx_pkg::PH_HEADER || ph == hlfx_pkg::PH_LEN) begin
      dv = digit_value(b);
      if (!dv[4]) begin
        ph = hlfx_pkg::PH_ERROR;
        return;
      end
      hex_acc = {hex_acc[19:0], dv[3:0]};
      dig_cnt = dig_cnt + 3'd1;
      if (ph == hlfx_pkg::PH_HEADER) begin
        if (dig_cnt >= hlfx_pkg::HDR_DIGITS) begin
          rec_size = (int'(hex_acc) > SIZE_CLAMP) ? 9'(SIZE_CLAMP) : hex_acc[8:0];
          rec_off = '0;
          fld_idx = '0;
          ph = hlfx_pkg::PH_LEN;
          hex_acc = '0;
          dig_cnt = '0;
        end
      end else if (dig_cnt >= hlfx_pkg::LEN_DIGITS) begin
        fsz = hex_acc[7:0];
        if (int'(fsz) + int'(rec_off) > int'(rec_size)) begin
          ph = hlfx_pkg::PH_ERROR;
          return;
        end
        rec_off = rec_off + 9'd2;
        fld_rem = fsz;
        if (fld_idx == hlfx_pkg::FIELD_LAST_NAME) lname_len = fsz;
        if (fld_idx == hlfx_pkg::FIELD_FIRST_NAME) fname_len = fsz;
        if (fsz == 8'd0) close_field();
        else ph = hlfx_pkg::PH_BODY;
      end
    end else if (ph == hlfx_pkg::PH_BODY) begin
      // name text stops at its first zero byte
      if (fld_idx == hlfx_pkg::FIELD_LAST_NAME) begin
        k = lname_len - fld_rem;
        lname_mem[k] = b;
        if (b == 8'd0) lname_zero = 1'b1;
        else if (!lname_zero) lname_eff++;
      end else if (fld_idx == hlfx_pkg::FIELD_FIRST_NAME) begin
        k = fname_len - fld_rem;
        fname_mem[k] = b;
        if (b == 8'd0) fname_zero = 1'b1;
        else if (!fname_zero) fname_eff++;
      end
      rec_off = rec_off + 9'd1;
      fld_rem = fld_rem - 8'd1;
      if (fld_rem == 8'd0) close_field();
    end
  endfunction

  // expected result of one command
  function automatic hlfx_pkg::out_item_t parse_and_fetch(hlfx_pkg::in_item_t it);
    hlfx_pkg::out_item_t r;
    int unsigned total;
    int unsigned p;
    r = '0;
    if (it.cmd == hlfx_pkg::CMD_START) begin
      restart_parse();
    end else if (it.cmd == hlfx_pkg::CMD_DATA) begin
      take_record_byte(it.data_byte);
    end else if (it.cmd == hlfx_pkg::CMD_FETCH && ph == hlfx_pkg::PH_READY) begin
      total = fname_eff + 1 + lname_eff;
      if (fetch_ptr < total) begin
        p = fetch_ptr;
        if (p < fname_eff) r.name_byte = fname_mem[p & 255];
        else if (p == fname_eff) r.name_byte = hlfx_pkg::SPACE_CHAR;
        else r.name_byte = lname_mem[(p - fname_eff - 1) & 255];
        r.name_valid = 1'b1;
        r.name_last = (p + 1 == total);
        fetch_ptr++;
      end
    end
    if (ph == hlfx_pkg::PH_READY) r.status = hlfx_pkg::STATUS_READY;
    else if (ph == hlfx_pkg::PH_ERROR) r.status = hlfx_pkg::STATUS_ERROR;
    else r.status = hlfx_pkg::STATUS_PARSING;
    return r;
  endfunction

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predicted_outputs.push_back(parse_and_fetch(in_data));
      if (!in_valid || in_ready) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99) >= gap_pct) begin
          in_valid <= 1'b1;
          in_data <= cmd_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output monitor and compare
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_outputs.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("unexpected result: status %0d byte %02h valid %0b last %0b",
                     out_data.status, out_data.name_byte, out_data.name_valid,
                     out_data.name_last);
          end
        end else begin
          popped_result = predicted_outputs.pop_front();
          if (out_data.status !== popped_result.status ||
              out_data.name_byte !== popped_result.name_byte ||
              out_data.name_valid !== popped_result.name_valid ||
              out_data.name_last !== popped_result.name_last) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
              $display("result mismatch: expected status %0d byte %02h valid %0b last %0b,",
                       popped_result.status, popped_result.name_byte,
                       popped_result.name_valid, popped_result.name_last);
              $display("  got status %0d byte %02h valid %0b last %0b",
                       out_data.status, out_data.name_byte, out_data.name_valid,
                       out_data.name_last);
            end
          end
        end
      end
      out_ready <= ($urandom_range(99) >= gap_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic void stage(logic [1:0] cmd, logic [7:0] b);
    hlfx_pkg::in_item_t it;
    it.cmd = cmd;
    it.data_byte = b;
    record_buf.push_back(it);
  endfunction

  function automatic void stage_text(string s);
    for (int i = 0; i < s.len(); i++) stage(hlfx_pkg::CMD_DATA, s[i]);
  endfunction

  function automatic void commit_record();
    foreach (record_buf[i]) cmd_backlog.push_back(record_buf[i]);
    staged_count += record_buf.size();
    record_buf.delete();
  endfunction

  // hex digits in mixed case, now and then a bad digit
  function automatic void stage_hex(logic [23:0] value, logic [2:0] digits);
    logic [3:0] nib;
    logic [7:0] c;
    logic [4:0] dv;
    for (int d = int'(digits) - 1; d >= 0; d--) begin
      nib = 4'(value >> (4 * d));
      if (nib < 4'd10) c = 8'h30 + 8'(nib);
      else c = ($urandom_range(1) ? 8'h37 : 8'h57) + 8'(nib);
      if ($urandom_range(149) == 0) begin
        do begin
          c = 8'($urandom_range(255));
          dv = digit_value(c);
        end while (dv[4]);
      end
      stage(hlfx_pkg::CMD_DATA, c);
    end
  endfunction

  // mostly printable, sometimes a zero or any byte
  function automatic logic [7:0] name_char();
    int unsigned roll;
    roll = $urandom_range(59);
    if (roll == 0) return 8'h00;
    if (roll == 1) return 8'($urandom_range(255));
    return 8'($urandom_range(8'h7e, 8'h21));
  endfunction

  // one record with fetches, sometimes cut short or followed by noise
  function automatic void build_record();
    int unsigned lens [5];
    int unsigned total;
    int unsigned roll;
    int unsigned cut;
    logic [23:0] size_val;
    total = int'(hlfx_pkg::NUM_FIELDS) * int'(hlfx_pkg::LEN_DIGITS);
    for (int f = 0; f < 5; f++) begin
      if (f >= int'(hlfx_pkg::FIELD_LAST_NAME) && $urandom_range(24) == 0) begin
        lens[f] = $urandom_range(255, 100);
      end else begin
        lens[f] = $urandom_range((f >= int'(hlfx_pkg::FIELD_LAST_NAME)) ? 8 : 5);
      end
      total += lens[f];
    end
    roll = $urandom_range(99);
    if (roll < 80) size_val = 24'(total);
    else if (roll < 90) size_val = 24'(total + $urandom_range(5, 1));
    else if (roll < 97) size_val = 24'(total - $urandom_range(3, 1));
    else size_val = 24'($urandom);
    stage(hlfx_pkg::CMD_START, 8'($urandom_range(255)));
    stage_hex(size_val, hlfx_pkg::HDR_DIGITS);
    for (int f = 0; f < 5; f++) begin
      stage_hex(24'(lens[f]), hlfx_pkg::LEN_DIGITS);
      for (int i = 0; i < int'(lens[f]); i++) begin
        stage(hlfx_pkg::CMD_DATA, (f >= int'(hlfx_pkg::FIELD_LAST_NAME)) ? name_char() :
                                  8'($urandom_range(255)));
      end
    end
    // read the name out, a little past its end
    repeat (lens[hlfx_pkg::FIELD_LAST_NAME] + lens[hlfx_pkg::FIELD_FIRST_NAME] + 1
            + $urandom_range(3)) begin
      roll = $urandom_range(19);
      if (roll == 0) stage(hlfx_pkg::CMD_DATA, 8'($urandom_range(255)));
      else if (roll == 1) stage(CMD_NOP, 8'($urandom_range(255)));
      stage(hlfx_pkg::CMD_FETCH, 8'($urandom_range(255)));
    end
    if ($urandom_range(19) == 0) begin
      cut = $urandom_range(record_buf.size() - 1, 1);
      while (record_buf.size() > cut) void'(record_buf.pop_back());
    end
    if ($urandom_range(5) == 0) begin
      repeat ($urandom_range(4, 1)) stage(2'($urandom_range(3)), 8'($urandom_range(255)));
    end
    commit_record();
  endfunction

  // name capacity register write, mirrored into name_cap
  task automatic write_capacity(logic [10:0] value);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    name_cap = value;
  endtask

  // wait for every command to be taken and every result to arrive
  task automatic drain();
    while (cmd_backlog.size() != 0 || in_valid || predicted_outputs.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    restart_parse();
    name_cap = hlfx_pkg::CAP_RESET;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_capacity(hlfx_pkg::CAP_RESET);

    // directed: no-op, fetch while parsing, a tiny record, reads past the end,
    // a byte after ready, then a bad header digit
    stage(CMD_NOP, 8'hff);
    stage(hlfx_pkg::CMD_FETCH, 8'h00);
    stage(hlfx_pkg::CMD_START, 8'h00);
    stage_text("00000D");
    stage_text("000000");
    stage_text("01Z");
    stage_text("02ab");
    repeat (5) stage(hlfx_pkg::CMD_FETCH, 8'h00);
    stage(hlfx_pkg::CMD_DATA, 8'h5a);
    stage(hlfx_pkg::CMD_START, 8'hff);
    stage(hlfx_pkg::CMD_DATA, "G");
    stage(hlfx_pkg::CMD_FETCH, 8'h00);
    stage(hlfx_pkg::CMD_DATA, "1");
    commit_record();
    drain();

    // random records over several capacities, one phase with no gaps
    phase_caps[0] = 11'd1024;
    phase_caps[1] = 11'd0;
    phase_caps[2] = 11'd12;
    phase_caps[3] = 11'($urandom_range(24, 6));
    phase_caps[4] = 11'($urandom_range(1024));
    phase_caps[5] = 11'd1023;
    phase_caps[6] = 11'd1;
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_capacity(phase_caps[p]);
      gap_pct = (p == 5) ? 0 : 29;
      staged_count = 0;
      while (staged_count < PHASE_ITEMS) build_record();
      drain();
    end

    if (predicted_outputs.size() != 0) mismatch_count++;
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
